// File: sv/ibbe_pkg.sv
// ----------------------------------------------------------------------------
// ibbe_pkg: shared types and constants for the idle blank / battery monitor
// Item modes, event codes, register indexes and the event bundle that moves
// from the classifier to the event sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ibbe_pkg;

	// Width of the activity clock kept inside the block
	localparam int TIME_BITS = 32;
	// Widest of the time clock and the timeout register, for the idle compare
	localparam int CMP_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;

	// Port field widths
	localparam int NOW_BITS     = 32;
	localparam int LEVEL_BITS   = 7;
	localparam int BL_BITS      = 8;
	localparam int TIMEOUT_BITS = 32;
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_IDX_BITS  = 1;

	// Register reset values
	localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET   = TIMEOUT_BITS'(60 * 1000);
	localparam logic [LEVEL_BITS-1:0]   LOW_BATT_RESET  = LEVEL_BITS'(15);

	// Register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_IDLE_TIMEOUT = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] CFG_LOW_BATTERY  = CFG_IDX_BITS'(1);

	// Most events one item can cause
	localparam int MAX_EVENTS = 3;
	localparam int EV_IDX_BITS = $clog2(MAX_EVENTS);
	localparam int EV_CNT_BITS = $clog2(MAX_EVENTS + 1);

	// Bundle queue depth
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
	localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

	typedef enum logic [1:0] {
		MODE_TICK     = 2'd0,
		MODE_ACTIVITY = 2'd1,
		MODE_KEEP     = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		EV_CHG_START = 3'd0,
		EV_CHG_STOP  = 3'd1,
		EV_LOW       = 3'd2,
		EV_WAKE      = 3'd3,
		EV_SLEEP     = 3'd4
	} event_kind_t;

	// One input word after unpacking
	typedef struct packed {
		mode_t                   mode;
		logic [NOW_BITS-1:0]     now_ms;
		logic [LEVEL_BITS-1:0]   battery_level;
		logic                    charging;
		logic                    input_seen;
		logic [BL_BITS-1:0]      backlight_now;
		logic                    keep_awake_request;
	} in_item_t;

	// One result word without its last marker
	typedef struct packed {
		event_kind_t           kind;
		logic [LEVEL_BITS-1:0] level;
		logic                  bl_write;
		logic [BL_BITS-1:0]    bl_value;
	} event_t;

	// All events of one item, packed from slot 0 up
	typedef struct packed {
		logic [EV_CNT_BITS-1:0]    count;
		event_t [MAX_EVENTS-1:0]   ev;
	} bundle_t;

endpackage

`default_nettype wire

// File: sv/idle_blank_and_battery_events.sv
// ----------------------------------------------------------------------------
// idle_blank_and_battery_events: idle screen blanking and battery monitor
// Watches sample ticks, user activity and keep-awake settings and reports
// charging changes, low battery, screen wake and screen blank events.
// ----------------------------------------------------------------------------
//  channel   direction  tdata (low bit first)                         tuser / tlast
//  s_axis    in         now_ms[31:0], battery_level[38:32],           tuser: mode
//                       charging[39], input_seen[40],
//                       backlight_now[48:41], keep_awake_request[49]
//  m_axis    out        event_level[6:0], backlight_write[7],         tuser: event_kind
//                       backlight_value[15:8]                         tlast: last_event
//  cfg       in         cfg_index 0 idle_timeout_ms, 1 low_battery_percent
//
// An input word is taken every cycle while the four-entry bundle queue has
// room; items that cause no event never enter the queue. The sequencer sends
// one event word a cycle while the output is not stalled, one per event
// an item causes (up to three), each through the queue, the bundle register
// and the output register. A stalled output fills the queue, then s_axis_tready
// drops. Reset clears control and monitor state, not stored data; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module idle_blank_and_battery_events (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire  [ibbe_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire  [ibbe_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	// now_ms, battery_level, charging, input_seen, backlight_now, keep_awake_request
	input  wire  [55:0]                         s_axis_tdata,
	// mode
	input  wire  [1:0]                          s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	// event_level, backlight_write, backlight_value
	output logic [15:0]                         m_axis_tdata,
	// event_kind
	output logic [2:0]                          m_axis_tuser,
	output logic                                m_axis_tlast
);
	import ibbe_pkg::*;

	in_item_t in_item;
	bundle_t  q_in;
	bundle_t  q_head;
	event_t   out_event;
	logic     q_push;
	logic     q_full;
	logic     q_pop;
	logic     q_valid;

	// Unpack the input word
	assign in_item.mode               = mode_t'(s_axis_tuser);
	assign in_item.now_ms             = s_axis_tdata[31:0];
	assign in_item.battery_level      = s_axis_tdata[38:32];
	assign in_item.charging           = s_axis_tdata[39];
	assign in_item.input_seen         = s_axis_tdata[40];
	assign in_item.backlight_now      = s_axis_tdata[48:41];
	assign in_item.keep_awake_request = s_axis_tdata[49];

	ibbe_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (in_item),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_in)
	);

	ibbe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (q_head)
	);

	ibbe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_event (out_event),
		.out_last  (m_axis_tlast)
	);

	// Pack the result word
	assign m_axis_tuser = out_event.kind;
	assign m_axis_tdata = {out_event.bl_value, out_event.bl_write, out_event.level};

endmodule

`default_nettype wire

// File: sv/ibbe_front.sv
// ----------------------------------------------------------------------------
// ibbe_front: item classifier and monitor state
// Takes one item a cycle unless the queue is full, updates the charging,
// battery and idle state, and queues the item's events as one bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module ibbe_front (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire  [ibbe_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  wire  [ibbe_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  ibbe_pkg::in_item_t                   in_item,
	input  wire                                  q_full,
	output logic                                 q_push,
	output ibbe_pkg::bundle_t                    q_data
);
	import ibbe_pkg::*;

	logic [TIMEOUT_BITS-1:0] idle_timeout_q;
	logic [LEVEL_BITS-1:0]   low_batt_q;

	logic [TIME_BITS-1:0]    last_act_q;
	logic                    blanked_q;
	logic                    stay_on_q;
	logic [BL_BITS-1:0]      saved_bl_q;
	logic                    prev_chg_q;
	logic                    low_rep_q;

	logic [TIME_BITS-1:0]    last_act_d;
	logic                    blanked_d;
	logic                    stay_on_d;
	logic [BL_BITS-1:0]      saved_bl_d;
	logic                    prev_chg_d;
	logic                    low_rep_d;

	logic                    accept;
	logic [TIME_BITS-1:0]    now_t;
	logic [TIME_BITS-1:0]    idle_time;
	logic                    idle_expired;
	logic                    chg_ev;
	logic                    low_ev;
	logic                    wake_ev;
	logic                    sleep_ev;
	logic [EV_IDX_BITS-1:0]  slot;
	bundle_t                 bundle;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// Idle time wraps modulo the clock width
	assign now_t        = TIME_BITS'(in_item.now_ms);
	assign idle_time    = now_t - last_act_q;
	assign idle_expired = CMP_BITS'(idle_time) > CMP_BITS'(idle_timeout_q);

	// Classify the item and work out the next monitor state
	always_comb begin
		last_act_d   = last_act_q;
		blanked_d    = blanked_q;
		stay_on_d    = stay_on_q;
		saved_bl_d   = saved_bl_q;
		prev_chg_d   = prev_chg_q;
		low_rep_d    = low_rep_q;
		chg_ev       = 1'b0;
		low_ev       = 1'b0;
		wake_ev      = 1'b0;
		sleep_ev     = 1'b0;
		unique case (in_item.mode)
			MODE_TICK: begin
				if (in_item.charging != prev_chg_q) begin
					chg_ev     = 1'b1;
					prev_chg_d = in_item.charging;
				end
				if (!in_item.charging && (in_item.battery_level <= low_batt_q) && !low_rep_q) begin
					low_ev    = 1'b1;
					low_rep_d = 1'b1;
				end
				if (in_item.battery_level > low_batt_q) begin
					low_rep_d = 1'b0;
				end
				if (in_item.input_seen) begin
					last_act_d = now_t;
					if (blanked_q) begin
						wake_ev   = 1'b1;
						blanked_d = 1'b0;
					end
				end else if (!stay_on_q && !blanked_q && idle_expired) begin
					sleep_ev   = 1'b1;
					saved_bl_d = in_item.backlight_now;
					blanked_d  = 1'b1;
				end
			end
			MODE_ACTIVITY: begin
				last_act_d = now_t;
				if (blanked_q) begin
					wake_ev   = 1'b1;
					blanked_d = 1'b0;
				end
			end
			MODE_KEEP: begin
				stay_on_d = in_item.keep_awake_request;
				if (in_item.keep_awake_request) begin
					last_act_d = now_t;
				end
			end
			default: begin
			end
		endcase
	end

	// Pack the events of this item into consecutive slots
	always_comb begin
		slot   = '0;
		bundle = '0;
		if (chg_ev) begin
			bundle.ev[slot].kind  = in_item.charging ? EV_CHG_START : EV_CHG_STOP;
			bundle.ev[slot].level = in_item.battery_level;
			slot = slot + EV_IDX_BITS'(1);
		end
		if (low_ev) begin
			bundle.ev[slot].kind  = EV_LOW;
			bundle.ev[slot].level = in_item.battery_level;
			slot = slot + EV_IDX_BITS'(1);
		end
		if (wake_ev) begin
			bundle.ev[slot].kind     = EV_WAKE;
			bundle.ev[slot].level    = in_item.battery_level;
			bundle.ev[slot].bl_write = 1'b1;
			bundle.ev[slot].bl_value = saved_bl_q;
		end
		if (sleep_ev) begin
			bundle.ev[slot].kind     = EV_SLEEP;
			bundle.ev[slot].level    = in_item.battery_level;
			bundle.ev[slot].bl_write = 1'b1;
		end
		bundle.count = EV_CNT_BITS'(chg_ev) + EV_CNT_BITS'(low_ev)
			+ EV_CNT_BITS'(wake_ev || sleep_ev);
	end

	// Push only items that cause at least one event
	assign q_push = accept && (bundle.count != '0);
	assign q_data = bundle;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_timeout_q <= TIMEOUT_RESET;
			low_batt_q     <= LOW_BATT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IDLE_TIMEOUT: idle_timeout_q <= TIMEOUT_BITS'(cfg_data);
				CFG_LOW_BATTERY:  low_batt_q     <= LEVEL_BITS'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// Monitor state, advanced on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_act_q   <= '0;
			blanked_q    <= 1'b0;
			stay_on_q    <= 1'b0;
			saved_bl_q   <= '0;
			prev_chg_q   <= 1'b0;
			low_rep_q    <= 1'b0;
		end else if (accept) begin
			last_act_q   <= last_act_d;
			blanked_q    <= blanked_d;
			stay_on_q    <= stay_on_d;
			saved_bl_q   <= saved_bl_d;
			prev_chg_q   <= prev_chg_d;
			low_rep_q    <= low_rep_d;
		end
	end

endmodule

`default_nettype wire

// File: sv/ibbe_queue.sv
// ----------------------------------------------------------------------------
// ibbe_queue: event bundle queue
// Short first-word-fall-through queue that decouples the classifier from the
// event sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ibbe_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  ibbe_pkg::bundle_t   push_data,
	output logic                full,
	input  wire                 pop,
	output logic                valid,
	output ibbe_pkg::bundle_t   head
);
	import ibbe_pkg::*;

	bundle_t                mem_q [Q_DEPTH];
	logic [Q_PTR_BITS-1:0]  wr_ptr_q;
	logic [Q_PTR_BITS-1:0]  rd_ptr_q;
	logic [Q_CNT_BITS-1:0]  count_q;
	logic                   do_push;
	logic                   do_pop;

	assign full    = (count_q == Q_CNT_BITS'(Q_DEPTH));
	assign valid   = (count_q != '0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	// Store pushed bundles
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_BITS'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_BITS'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + Q_CNT_BITS'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - Q_CNT_BITS'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/ibbe_back.sv
// ----------------------------------------------------------------------------
// ibbe_back: event sequencer
// Takes bundles from the queue and sends their events one word a cycle while
// not stalled, through an output register, marking each item's last event.
// ----------------------------------------------------------------------------
`default_nettype none

module ibbe_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 q_valid,
	input  ibbe_pkg::bundle_t   q_head,
	output logic                q_pop,
	output logic                out_valid,
	input  wire                 out_ready,
	output ibbe_pkg::event_t    out_event,
	output logic                out_last
);
	import ibbe_pkg::*;

	bundle_t                bundle_q;
	logic                   bvalid_q;
	logic [EV_IDX_BITS-1:0] idx_q;
	logic                   out_valid_q;
	event_t                 out_event_q;
	logic                   out_last_q;
	logic                   emit;
	logic                   emit_last;

	// Send one event when the output register frees up
	assign emit      = bvalid_q && (!out_valid_q || out_ready);
	assign emit_last = emit && (EV_CNT_BITS'(idx_q) == bundle_q.count - EV_CNT_BITS'(1));
	assign q_pop     = q_valid && (!bvalid_q || emit_last);

	// Current bundle and event index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvalid_q <= 1'b0;
			idx_q    <= '0;
		end else if (q_pop) begin
			bvalid_q <= 1'b1;
			idx_q    <= '0;
		end else if (emit_last) begin
			bvalid_q <= 1'b0;
		end else if (emit) begin
			idx_q <= idx_q + EV_IDX_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			bundle_q <= q_head;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_event_q <= bundle_q.ev[idx_q];
			out_last_q  <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_event = out_event_q;
	assign out_last  = out_last_q;

endmodule

`default_nettype wire

// File: sv/ibbe_checker.sv
// ----------------------------------------------------------------------------
// ibbe_checker: port-level checks for the idle blank / battery monitor
// Watches the result channel for held stalled words, legal event codes,
// consistent backlight fields and last marks, and is bound onto the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ibbe_checker (
	input wire                                 clk,
	input wire                                 arst_n,
	input wire                                 m_axis_tvalid,
	input wire                                 m_axis_tready,
	input wire  [15:0]                         m_axis_tdata,
	input wire  [2:0]                          m_axis_tuser,
	input wire                                 m_axis_tlast
);
	import ibbe_pkg::*;

	// Hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result word changed while stalled");

	// Only defined event codes leave the block
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser <= EV_SLEEP))
		else $error("undefined event code");

	// Backlight write goes with wake and blank events only
	a_bl_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[7] == ((m_axis_tuser == EV_WAKE)
			|| (m_axis_tuser == EV_SLEEP))))
		else $error("backlight write flag does not match event");

	// Blanking sets the backlight to zero, other non-writing events carry zero
	a_bl_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != EV_WAKE) |-> (m_axis_tdata[15:8] == '0))
		else $error("nonzero backlight value");

	// A wake or blank event always closes its item
	a_pm_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && ((m_axis_tuser == EV_WAKE) || (m_axis_tuser == EV_SLEEP))
			|-> m_axis_tlast)
		else $error("wake or blank event not last of its item");

endmodule

bind idle_blank_and_battery_events ibbe_checker u_ibbe_checker (.*);

`default_nettype wire

// File: tb/sv/idle_blank_and_battery_events_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idle_blank_and_battery_events_tb: self-checking bench for the power monitor
// Sends sample ticks, activity notes and keep-awake words with random gaps.
// A cycle-free copy of the monitor predicts every event word. Each word that
// comes out is checked in order against that prediction, under several
// timeout and threshold settings, the extremes among them.
// ----------------------------------------------------------------------------

module idle_blank_and_battery_events_tb;
	import ibbe_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 10;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_ITEMS  = 68;

	// Mode code that the block ignores
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]  mode;
		logic [31:0] now_ms;
		logic [6:0]  level;
		logic        charging;
		logic        input_seen;
		logic [7:0]  backlight;
		logic        keep_req;
	} monitor_item_t;

	typedef struct {
		event_kind_t kind;
		logic [6:0]  level;
		logic        bl_write;
		logic [7:0]  bl_value;
		logic        last;
	} power_event_t;

	// Predicted monitor state plus the queue of events still owed by the block
	class power_event_scoreboard;
		logic [31:0]  idle_timeout;
		logic [6:0]   low_threshold;
		logic [31:0]  last_activity;
		logic         blanked;
		logic         stay_on;
		logic         prev_charging;
		logic         low_reported;
		logic [7:0]   saved_backlight;
		power_event_t pending_events[$];
		int           errors;

		function new();
			idle_timeout    = TIMEOUT_RESET;
			low_threshold   = LOW_BATT_RESET;
			last_activity   = '0;
			blanked         = 1'b0;
			stay_on         = 1'b0;
			prev_charging   = 1'b0;
			low_reported    = 1'b0;
			saved_backlight = '0;
			errors          = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] index, logic [31:0] data);
			if (index == CFG_IDLE_TIMEOUT)
				idle_timeout = data;
			else if (index == CFG_LOW_BATTERY)
				low_threshold = data[6:0];
		endfunction

		function power_event_t make_event(event_kind_t kind, logic [6:0] level,
				logic bl_write, logic [7:0] bl_value);
			power_event_t ev;
			ev.kind     = kind;
			ev.level    = level;
			ev.bl_write = bl_write;
			ev.bl_value = bl_value;
			ev.last     = 1'b0;
			return ev;
		endfunction

		// Predict the events of one accepted word, in the order they leave
		function void note_input(monitor_item_t it);
			power_event_t batch[$];
			power_event_t ev;
			logic [31:0]  idle_ms;
			idle_ms = it.now_ms - last_activity;
			// charging edge and low battery only look at ticks
			if (it.mode == MODE_TICK) begin
				if (it.charging != prev_charging) begin
					prev_charging = it.charging;
					batch.push_back(make_event(it.charging ? EV_CHG_START : EV_CHG_STOP,
						it.level, 1'b0, 8'h00));
				end
				if (!it.charging && it.level <= low_threshold && !low_reported) begin
					low_reported = 1'b1;
					batch.push_back(make_event(EV_LOW, it.level, 1'b0, 8'h00));
				end
				if (it.level > low_threshold)
					low_reported = 1'b0;
			end
			// activity restarts the idle clock and wakes; else a quiet tick may blank
			if ((it.mode == MODE_TICK && it.input_seen) || it.mode == MODE_ACTIVITY) begin
				last_activity = it.now_ms;
				if (blanked) begin
					blanked = 1'b0;
					batch.push_back(make_event(EV_WAKE, it.level, 1'b1, saved_backlight));
				end
			end else if (it.mode == MODE_TICK && !stay_on && !blanked &&
					idle_ms > idle_timeout) begin
				saved_backlight = it.backlight;
				blanked = 1'b1;
				batch.push_back(make_event(EV_SLEEP, it.level, 1'b1, 8'h00));
			end else if (it.mode == MODE_KEEP) begin
				stay_on = it.keep_req;
				if (it.keep_req)
					last_activity = it.now_ms;
			end
			// mark the final event of the word
			foreach (batch[i]) begin
				ev = batch[i];
				ev.last = (i == batch.size() - 1);
				pending_events.push_back(ev);
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		// Check one accepted event word against the oldest prediction
		function void check_result(logic [2:0] kind, logic [6:0] level, logic bl_write,
				logic [7:0] bl_value, logic last);
			power_event_t want;
			if (pending_events.size() == 0) begin
				$error("event word with nothing predicted: kind %0d level %0d", kind, level);
				errors++;
				return;
			end
			want = pending_events.pop_front();
			compare_field("event_kind", 32'(want.kind), 32'(kind));
			compare_field("event_level", 32'(want.level), 32'(level));
			compare_field("backlight_write", 32'(want.bl_write), 32'(bl_write));
			compare_field("backlight_value", 32'(want.bl_value), 32'(bl_value));
			compare_field("last_event", 32'(want.last), 32'(last));
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n = 1'b0;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;
	logic                     s_axis_tvalid;
	logic                     s_axis_tready;
	// now_ms, battery_level, charging, input_seen, backlight_now, keep_awake_request
	logic [55:0]              s_axis_tdata;
	// mode
	logic [1:0]               s_axis_tuser;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready;
	// event_level, backlight_write, backlight_value
	logic [15:0]              m_axis_tdata;
	// event_kind
	logic [2:0]               m_axis_tuser;
	logic                     m_axis_tlast;

	// no idling on either side while set
	bit                       steady = 1'b0;
	int                       cycle_count;
	power_event_scoreboard    sb = new();

	idle_blank_and_battery_events i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Generate the clock
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Stop a hung run
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// Take event words with a random stall before each
	initial begin
		int stall;
		m_axis_tready <= 1'b0;
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			stall = steady ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			sb.check_result(m_axis_tuser, m_axis_tdata[6:0], m_axis_tdata[7],
				m_axis_tdata[15:8], m_axis_tlast);
		end
	end

	function automatic monitor_item_t make_item(logic [1:0] mode, logic [31:0] now_ms,
			logic [6:0] level, logic charging, logic input_seen, logic [7:0] backlight,
			logic keep_req);
		monitor_item_t it;
		it.mode       = mode;
		it.now_ms     = now_ms;
		it.level      = level;
		it.charging   = charging;
		it.input_seen = input_seen;
		it.backlight  = backlight;
		it.keep_req   = keep_req;
		return it;
	endfunction

	// Offer one word after a random gap and hold it until taken
	task automatic send_item(monitor_item_t it);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'b0, it.keep_req, it.backlight, it.input_seen, it.charging,
			it.level, it.now_ms};
		s_axis_tuser  <= it.mode;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_input(it);
	endtask

	// Drop valid and wait until the block owes nothing
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.pending_events.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write one register; the caller drops the enable after its last write
	task automatic cfg_write(logic [CFG_IDX_BITS-1:0] index, logic [31:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(index, data);
	endtask

	// One setting, then random words on an advancing clock
	task automatic run_phase(logic [31:0] timeout, logic [6:0] threshold, bit calm);
		monitor_item_t it;
		logic [31:0]   clock_ms;
		logic          chg;
		int unsigned   span;
		int            lo;
		int            hi;
		int            pick;
		settle();
		cfg_write(CFG_IDLE_TIMEOUT, timeout);
		cfg_write(CFG_LOW_BATTERY, {25'b0, threshold});
		cfg_we <= 1'b0;
		span = (timeout > 3000) ? 3000 : timeout + 2;
		lo = (int'(threshold) < 3) ? 0 : int'(threshold) - 3;
		hi = (int'(threshold) > 124) ? 127 : int'(threshold) + 3;
		clock_ms = $urandom;
		chg = 1'($urandom_range(0, 1));
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			// alternate stretches with and without idling
			if (n % 24 == 0)
				steady = calm || ($urandom_range(0, 3) == 0);
			// advance time, with an occasional jump anywhere
			if ($urandom_range(0, 99) < 5)
				clock_ms = $urandom;
			else
				clock_ms += $urandom_range(0, 2 * span);
			pick = $urandom_range(0, 99);
			if (pick < 70)
				it.mode = MODE_TICK;
			else if (pick < 85)
				it.mode = MODE_ACTIVITY;
			else if (pick < 96)
				it.mode = MODE_KEEP;
			else
				it.mode = MODE_UNUSED;
			// levels mostly around the threshold
			case ($urandom_range(0, 9))
				0: it.level = 7'($urandom_range(0, 127));
				1, 2, 3: it.level = 7'($urandom_range(0, 100));
				default: it.level = 7'($urandom_range(lo, hi));
			endcase
			if ($urandom_range(0, 99) < 15)
				chg = ~chg;
			it.now_ms     = clock_ms;
			it.charging   = chg;
			it.input_seen = ($urandom_range(0, 99) < 20);
			it.backlight  = 8'($urandom);
			it.keep_req   = ($urandom_range(0, 2) == 0);
			send_item(it);
		end
	endtask

	// Reset, directed words, random phases, drain and report
	initial begin
		cfg_we        <= 1'b0;
		cfg_index     <= '0;
		cfg_data      <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// charging edges and the one-shot low battery report
		send_item(make_item(MODE_TICK, 32'd0, 7'd100, 1'b0, 1'b0, 8'h00, 1'b0));
		send_item(make_item(MODE_TICK, 32'd1000, 7'd50, 1'b1, 1'b0, 8'h00, 1'b0));
		send_item(make_item(MODE_TICK, 32'd2000, 7'd10, 1'b0, 1'b0, 8'h00, 1'b0));
		send_item(make_item(MODE_TICK, 32'd3000, 7'd5, 1'b0, 1'b0, 8'h00, 1'b0));
		send_item(make_item(MODE_TICK, 32'd4000, 7'd16, 1'b0, 1'b0, 8'h00, 1'b0));
		// level at the threshold plus a blank in the same tick
		send_item(make_item(MODE_TICK, 32'd63000, 7'd15, 1'b0, 1'b0, 8'hFF, 1'b0));
		send_item(make_item(MODE_TICK, 32'd63500, 7'd127, 1'b1, 1'b0, 8'h00, 1'b0));
		// three events from one tick: charging, low battery, wake
		send_item(make_item(MODE_TICK, 32'd64000, 7'd0, 1'b0, 1'b1, 8'h00, 1'b0));
		// activity while awake
		send_item(make_item(MODE_ACTIVITY, 32'd65000, 7'd77, 1'b0, 1'b0, 8'h00, 1'b0));
		// idle time equal to the timeout, then one past it
		send_item(make_item(MODE_TICK, 32'd125000, 7'd50, 1'b0, 1'b0, 8'h55, 1'b0));
		send_item(make_item(MODE_TICK, 32'd125001, 7'd50, 1'b0, 1'b0, 8'hAA, 1'b0));
		send_item(make_item(MODE_ACTIVITY, 32'd130000, 7'd100, 1'b0, 1'b0, 8'h00, 1'b0));
		// keep awake holds off the blank; clearing it does not restart the clock
		send_item(make_item(MODE_KEEP, 32'd131000, 7'd0, 1'b0, 1'b0, 8'h00, 1'b1));
		send_item(make_item(MODE_TICK, 32'd300000, 7'd60, 1'b0, 1'b0, 8'h33, 1'b0));
		send_item(make_item(MODE_KEEP, 32'd300000, 7'd0, 1'b0, 1'b0, 8'h00, 1'b0));
		send_item(make_item(MODE_TICK, 32'd300001, 7'd60, 1'b0, 1'b0, 8'h01, 1'b0));
		// unused mode with every field high
		send_item(make_item(MODE_UNUSED, 32'hFFFF_FFFF, 7'd127, 1'b1, 1'b1, 8'hFF, 1'b1));
		// idle time across the wrap of the millisecond clock
		send_item(make_item(MODE_ACTIVITY, 32'hFFFF_FF00, 7'd3, 1'b0, 1'b0, 8'h00, 1'b0));
		send_item(make_item(MODE_TICK, 32'h0000_E000, 7'd3, 1'b0, 1'b0, 8'h80, 1'b0));
		send_item(make_item(MODE_TICK, 32'h0000_EB00, 7'd3, 1'b0, 1'b0, 8'h7F, 1'b0));
		send_item(make_item(MODE_TICK, 32'h0000_EC00, 7'd100, 1'b1, 1'b1, 8'h00, 1'b0));

		run_phase(32'd200, 7'd30, 1'b0);
		run_phase(32'd0, 7'd0, 1'b0);
		run_phase(32'hFFFF_FFFF, 7'd100, 1'b0);
		run_phase(32'd1000, 7'd50, 1'b1);
		run_phase(32'd37, 7'd127, 1'b0);
		run_phase(32'd60000, 7'd15, 1'b0);
		settle();

		if (sb.errors == 0 && sb.pending_events.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
